// File: hw/rtl/ets_pkg.sv
package ets_pkg;

    localparam int PAGE_BYTES  = 1024;
    localparam int TABLE_UNITS = 256;

    localparam int WORD_W = 32;
    localparam int UNIT_W = 8;
    localparam int ADDR_W = 26;
    localparam int SIZE_W = 18;
    localparam int IRQ_W  = 8;
    localparam int SLOT_W = 8;

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    localparam logic [UNIT_W-1:0] UNIT_START = UNIT_W'(2);
    localparam logic [ADDR_W-1:0] ADDR_START = ADDR_W'(3 * PAGE_BYTES);
    localparam logic [IRQ_W-1:0]  IRQ_START  = IRQ_W'(1);
    localparam logic [UNIT_W:0]   UNIT_LIMIT = (UNIT_W + 1)'(TABLE_UNITS);

    localparam int NEXT_BIT = 31;

    typedef enum logic [2:0] {
        ST_CONTINUE  = 3'd0,
        ST_CRC_ERR   = 3'd1,
        ST_TABLE_END = 3'd2,
        ST_UNITS_OUT = 3'd3,
        ST_IGNORED   = 3'd4
    } t_status;

    typedef struct packed {
        logic                  engine_found;
        logic [7:0]            engine_kind;
        logic [3:0]            engine_version;
        logic [UNIT_W-1:0]     unit_index;
        logic [ADDR_W-1:0]     base_address;
        logic [SIZE_W-1:0]     area_size;
        logic [IRQ_W-1:0]      irq_bit;
        t_status               status;
    } t_result;

    // CRC-4 nibble table, polynomial x^4+x^2+x+1
    function automatic logic [3:0] crc_nibble(input logic [3:0] idx);
        logic [3:0] v;
        case (idx)
            4'h0: v = 4'h0;
            4'h1: v = 4'h7;
            4'h2: v = 4'he;
            4'h3: v = 4'h9;
            4'h4: v = 4'hb;
            4'h5: v = 4'hc;
            4'h6: v = 4'h5;
            4'h7: v = 4'h2;
            4'h8: v = 4'h1;
            4'h9: v = 4'h6;
            4'ha: v = 4'hf;
            4'hb: v = 4'h8;
            4'hc: v = 4'ha;
            4'hd: v = 4'hd;
            4'he: v = 4'h4;
            default: v = 4'h3;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/ets_crc_check.sv
module ets_crc_check (
    input  logic [ets_pkg::WORD_W-1:0] i_word,
    output logic                       o_crc_ok
);
    import ets_pkg::*;

    logic [3:0] crc;

    // run seven nibbles, most significant first
    always_comb begin
        crc = 4'h0;
        for (int k = 7; k >= 1; k--) begin
            crc = crc_nibble(crc ^ i_word[4*k +: 4]);
        end
    end

    assign o_crc_ok = (crc == i_word[3:0]);

endmodule

// File: hw/rtl/ets_scan_state.sv
module ets_scan_state (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [ets_pkg::WORD_W-1:0] i_word,
    input  logic                       i_first,
    input  logic                       i_crc_ok,
    output ets_pkg::t_result           o_result
);
    import ets_pkg::*;

    logic              r_active;
    logic [UNIT_W-1:0] r_unit;
    logic [ADDR_W-1:0] r_addr;
    logic [IRQ_W-1:0]  r_irq;

    logic              n_active;
    logic [UNIT_W-1:0] n_unit;
    logic [ADDR_W-1:0] n_addr;
    logic [IRQ_W-1:0]  n_irq;

    logic              act;
    logic [UNIT_W-1:0] unit;
    logic [ADDR_W-1:0] addr;
    logic [IRQ_W-1:0]  irq;
    logic [SLOT_W-1:0] slots;
    logic [7:0]        etype;
    logic [ADDR_W-1:0] size;
    logic [UNIT_W:0]   unit_inc;
    logic              found;

    always_comb begin
        // a first word restarts the walk before it is handled
        act   = r_active | i_first;
        unit  = i_first ? UNIT_START : r_unit;
        addr  = i_first ? ADDR_START : r_addr;
        irq   = i_first ? IRQ_START  : r_irq;
        slots = i_word[23:16];
        etype = i_word[11:4];
        size  = ADDR_W'(slots) << PAGE_SHIFT;
        unit_inc = {1'b0, unit} + (UNIT_W + 1)'(1);
        found = (etype != 8'd0) && (slots != '0);

        o_result = '0;
        n_active = r_active;
        n_unit   = r_unit;
        n_addr   = r_addr;
        n_irq    = r_irq;

        if (!act) begin
            o_result.status = ST_IGNORED;
        end else begin
            o_result.unit_index   = unit;
            o_result.base_address = addr;
            n_unit = unit;
            n_addr = addr;
            n_irq  = irq;
            if ({1'b0, unit} >= UNIT_LIMIT) begin
                o_result.status = ST_UNITS_OUT;
                n_active = 1'b0;
            end else if (!i_crc_ok) begin
                o_result.status = ST_CRC_ERR;
                n_active = 1'b0;
            end else begin
                o_result.engine_kind    = etype;
                o_result.engine_version = i_word[15:12];
                o_result.area_size      = size[SIZE_W-1:0];
                if (found) begin
                    o_result.engine_found = 1'b1;
                    o_result.irq_bit      = irq;
                    n_irq = irq + IRQ_W'(1);
                end
                n_addr = addr + size;
                n_unit = unit_inc[UNIT_W-1:0];
                if (!i_word[NEXT_BIT]) begin
                    o_result.status = ST_TABLE_END;
                    n_active = 1'b0;
                end else if (unit_inc >= UNIT_LIMIT) begin
                    o_result.status = ST_UNITS_OUT;
                    n_active = 1'b0;
                end else begin
                    o_result.status = ST_CONTINUE;
                    n_active = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_unit   <= UNIT_START;
            r_addr   <= ADDR_START;
            r_irq    <= IRQ_START;
        end else if (i_step) begin
            r_active <= n_active;
            r_unit   <= n_unit;
            r_addr   <= n_addr;
            r_irq    <= n_irq;
        end
    end

endmodule

// File: hw/rtl/engine_table_scanner_core.sv
// Engine table scanner: takes one 32-bit configuration table word per transfer and returns
// exactly one result per word, in order. A word goes into an input register, is checked
// (CRC-4 over bits 31..4) and decoded against the running unit, address and interrupt
// counters while it waits there, and its result lands in the output register; a new word
// can be taken every cycle while o_in_stall is low. The input register and the output
// register are separate stages: while a finished result waits on i_out_stall, one more
// word is still taken into the input register, and the input stalls only once both are
// full. Set i_first_word on the word for unit 2 to start a scan; words seen with no scan
// running come back with status "ignored".
module engine_table_scanner_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [ets_pkg::WORD_W-1:0] i_table_word,
    input  logic                       i_first_word,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_engine_found,
    output logic [7:0]                 o_engine_kind,
    output logic [3:0]                 o_engine_version,
    output logic [ets_pkg::UNIT_W-1:0] o_unit_index,
    output logic [ets_pkg::ADDR_W-1:0] o_base_address,
    output logic [ets_pkg::SIZE_W-1:0] o_area_size,
    output logic [ets_pkg::IRQ_W-1:0]  o_irq_bit,
    output logic [2:0]                 o_status
);
    import ets_pkg::*;

    logic              r_in_valid;
    logic [WORD_W-1:0] r_word;
    logic              r_first;
    logic              r_out_valid;
    t_result           r_result;

    logic    out_ready;
    logic    step;
    logic    crc_ok;
    t_result result;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;

    ets_crc_check u_crc (
        .i_word   (r_word),
        .o_crc_ok (crc_ok)
    );

    ets_scan_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_word   (r_word),
        .i_first  (r_first),
        .i_crc_ok (crc_ok),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload: load on transfer, hold otherwise
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_word  <= i_table_word;
            r_first <= i_first_word;
        end
        if (step) begin
            r_result <= result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_engine_found   = r_result.engine_found;
    assign o_engine_kind    = r_result.engine_kind;
    assign o_engine_version = r_result.engine_version;
    assign o_unit_index     = r_result.unit_index;
    assign o_base_address   = r_result.base_address;
    assign o_area_size      = r_result.area_size;
    assign o_irq_bit        = r_result.irq_bit;
    assign o_status         = r_result.status;

    a_no_stall_when_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> !o_in_stall)
        else $error("input stalled while output register is free");

    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_in_stall)
        else $error("input stalled while input register is empty");

    a_found_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.engine_found) |->
        (r_result.status == ST_CONTINUE || r_result.status == ST_TABLE_END ||
         r_result.status == ST_UNITS_OUT))
        else $error("engine reported on a failed or ignored word");

    a_crc_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.status == ST_CRC_ERR) |->
        (r_result.area_size == '0 && r_result.irq_bit == '0 && !r_result.engine_found))
        else $error("CRC error result carries decoded fields");

    a_step_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("processed word did not reach the output register");

endmodule
